// ===== src/sdr_pkg.sv =====
package sdr_pkg;

  localparam int VALUE_W       = 32;
  localparam int SLOT_FIELD_W  = 5;
  localparam int COUNT_FIELD_W = 6;
  localparam int CAPACITY_DEF  = 32;

  // control bits of a probe as it walks the cell row
  typedef struct packed {
    logic valid;   // beat present in this stage
    logic active;  // nonzero and not yet matched or stored
    logic kept;    // stored by some earlier cell
    logic last;    // final beat of the set
  } probe_flags_t;

endpackage

// ===== src/sdr_in_if.sv =====
interface sdr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdr_pkg::VALUE_W-1:0]  value;
  logic                                set_last;

  modport source (output valid, output value, output set_last, input ready);
  modport sink   (input valid, input value, input set_last, output ready);
endinterface

// ===== src/sdr_out_if.sv =====
interface sdr_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [sdr_pkg::VALUE_W-1:0]       value_out;
  logic                                     kept;
  logic        [sdr_pkg::SLOT_FIELD_W-1:0]  slot;
  logic        [sdr_pkg::COUNT_FIELD_W-1:0] distinct_count;
  logic                                     overflow;
  logic                                     set_end;

  modport source (output valid, output value_out, output kept, output slot,
                  output distinct_count, output overflow, output set_end,
                  input ready);
  modport sink   (input valid, input value_out, input kept, input slot,
                  input distinct_count, input overflow, input set_end,
                  output ready);
endinterface

// ===== src/stream_duplicate_remover.sv =====
// stream_duplicate_remover: order-preserving duplicate removal, one row of CAPACITY cells.
// Each beat passes through the CAPACITY cell registers in order before its result is valid.
// Throughput: one beat per cycle; the whole row stalls while the output beat is held.
// Reset (rst, synchronous, active high) empties every cell and drops beats in flight.
// Each set's store clears as its last beat passes each cell; no clearing pass needed.
module stream_duplicate_remover #(
  parameter int CAPACITY = sdr_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sdr_in_if.sink    in_ch,
  sdr_out_if.source out_ch
);
  import sdr_pkg::*;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // probe signals between cells; index k is the input of cell k,
  // index CAPACITY is the registered output of the last cell
  probe_flags_t              p_flags [0:CAPACITY];
  logic signed [VALUE_W-1:0] p_value [0:CAPACITY];
  logic        [SLOT_W-1:0]  p_slot  [0:CAPACITY];
  logic        [CNT_W-1:0]   p_count [0:CAPACITY];

  logic        advance;
  logic [31:0] slot_ext;
  logic [31:0] count_ext;

  // the row moves as one: only blocked by a result beat waiting at the output
  assign advance     = !p_flags[CAPACITY].valid || out_ch.ready;
  assign in_ch.ready = advance;

  // a fresh probe: zero is never compared or stored, so it starts inactive
  assign p_flags[0].valid  = in_ch.valid;
  assign p_flags[0].active = (in_ch.value != '0);
  assign p_flags[0].kept   = 1'b0;
  assign p_flags[0].last   = in_ch.set_last;
  assign p_value[0]        = in_ch.value;
  assign p_slot[0]         = '0;
  assign p_count[0]        = '0;

  // each cell matches against its held value, or takes the value if it is empty;
  // entries fill in order, so the first empty cell is the next compacted slot
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    sdr_cell #(
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W),
      .INDEX  (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .flags_in  (p_flags[k]),
      .value_in  (p_value[k]),
      .slot_in   (p_slot[k]),
      .count_in  (p_count[k]),
      .flags_out (p_flags[k+1]),
      .value_out (p_value[k+1]),
      .slot_out  (p_slot[k+1]),
      .count_out (p_count[k+1])
    );
  end

  // result fields; slot and count are given in their low bits only
  assign slot_ext  = 32'(p_slot[CAPACITY]);
  assign count_ext = 32'(p_count[CAPACITY]);

  assign out_ch.valid          = p_flags[CAPACITY].valid;
  assign out_ch.value_out      = p_value[CAPACITY];
  assign out_ch.kept           = p_flags[CAPACITY].kept;
  assign out_ch.slot           = p_flags[CAPACITY].kept ? slot_ext[SLOT_FIELD_W-1:0] : '0;
  assign out_ch.distinct_count = count_ext[COUNT_FIELD_W-1:0];
  // still unresolved after the last cell: new but every cell was full
  assign out_ch.overflow       = p_flags[CAPACITY].active;
  assign out_ch.set_end        = p_flags[CAPACITY].last;

`ifndef NO_ASSERTIONS
  // a beat is never both stored and dropped
  a_kept_not_ovf: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.kept && out_ch.overflow))
    else $error("beat both kept and overflowed");

  // an overflow beat saw every cell occupied
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.overflow) |-> (p_count[CAPACITY] == CNT_W'(CAPACITY)))
    else $error("overflow with a free cell");

  // a kept beat takes the slot just past the earlier distinct values
  a_kept_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kept) |->
      (p_count[CAPACITY] == CNT_W'(p_slot[CAPACITY]) + CNT_W'(1)))
    else $error("kept slot does not match distinct count");

  // a held result beat moves nothing in the row
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(p_count[CAPACITY])))
    else $error("row advanced while output stalled");
`endif

endmodule

// ===== src/sdr_cell.sv =====
module sdr_cell #(
  parameter int SLOT_W = 5,
  parameter int CNT_W  = 6,
  parameter int INDEX  = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  sdr_pkg::probe_flags_t              flags_in,
  input  logic signed [sdr_pkg::VALUE_W-1:0] value_in,
  input  logic        [SLOT_W-1:0]           slot_in,
  input  logic        [CNT_W-1:0]            count_in,
  output sdr_pkg::probe_flags_t              flags_out,
  output logic signed [sdr_pkg::VALUE_W-1:0] value_out,
  output logic        [SLOT_W-1:0]           slot_out,
  output logic        [CNT_W-1:0]            count_out
);
  import sdr_pkg::*;

  logic                       held_valid;
  logic signed [VALUE_W-1:0]  held_value;
  logic                       hit;
  logic                       store;

  assign hit   = flags_in.valid && flags_in.active && held_valid && (held_value == value_in);
  assign store = flags_in.valid && flags_in.active && !held_valid;

  // held entry; cleared as the last beat of a set passes
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (advance && flags_in.valid) begin
      if (flags_in.last) begin
        held_valid <= 1'b0;
      end else if (store) begin
        held_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store) begin
      held_value <= value_in;
    end
  end

  // probe stage
  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else if (advance) begin
      flags_out.valid  <= flags_in.valid;
      flags_out.active <= flags_in.active && !hit && !store;
      flags_out.kept   <= flags_in.kept || store;
      flags_out.last   <= flags_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      value_out <= value_in;
      slot_out  <= store ? SLOT_W'(INDEX) : slot_in;
      count_out <= count_in + CNT_W'(held_valid || store);
    end
  end

endmodule

// ===== bench/stream_duplicate_remover_test.sv =====
module stream_duplicate_remover_test;
  import sdr_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  // Cycles with no beat moving on either side before the run is abandoned.
  // The worst honest stretch is a full row of CAP cells plus the longest
  // stall drawn on each side, so this leaves a wide margin.
  localparam int STALL_LIMIT = 2000;

  localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7fff_ffff;

  // One result beat, as the checker expects to see it
  typedef struct packed {
    logic signed [VALUE_W-1:0]       value;
    logic                            kept;
    logic        [SLOT_FIELD_W-1:0]  slot;
    logic        [COUNT_FIELD_W-1:0] count;
    logic                            overflow;
    logic                            set_end;
  } dedup_result_t;

  logic clk;
  logic rst;

  sdr_in_if  in_ch ();
  sdr_out_if out_ch ();

  stream_duplicate_remover #(.CAPACITY(CAP)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: distinct values of the set in progress, in arrival
  // order, so the index of a value is its compacted slot.
  logic signed [VALUE_W-1:0] set_values[$];
  dedup_result_t             pending_results[$];

  // Idle shaping, changed per test; each side redraws its wait per beat
  int unsigned src_gap_max;
  int unsigned sink_stall_max;

  int errors;
  int idle_cycles;
  int n_sets, n_beats, n_kept, n_repeats, n_zeros, n_overflow;

  always #5 clk = ~clk;

  // Work out the result of one input beat and move the set store on.
  // Zero is never compared or stored; a new value with the store full is
  // dropped and not remembered, so its next repeat overflows again.
  function automatic dedup_result_t predict_dedup(logic signed [VALUE_W-1:0] v,
                                                  logic last);
    dedup_result_t r;
    bit            found;
    found = 1'b0;
    foreach (set_values[i])
      if (set_values[i] == v) found = 1'b1;
    r         = '0;
    r.value   = v;
    r.set_end = last;
    if (v != 0 && !found) begin
      if (set_values.size() < CAP) begin
        r.slot = SLOT_FIELD_W'(set_values.size());
        r.kept = 1'b1;
        set_values.push_back(v);
      end else begin
        r.overflow = 1'b1;
      end
    end
    // count is taken after this beat, before the end-of-set clear
    r.count = COUNT_FIELD_W'(set_values.size());
    if (last) set_values.delete();
    return r;
  endfunction

  // Offer one beat after a random gap and hold it until the block takes it.
  // valid stays high across back-to-back beats, so it only drops when a
  // gap is actually drawn.
  task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic last);
    int unsigned   gap;
    dedup_result_t r;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.value    <= v;
    in_ch.set_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_dedup(v, last);
    pending_results.push_back(r);
    n_beats++;
    if (last) n_sets++;
    if (r.kept) n_kept++;
    if (r.overflow) n_overflow++;
    if (v == 0) n_zeros++;
    else if (!r.kept && !r.overflow) n_repeats++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Value mix: mostly a narrow band around zero so repeats are common,
  // with the extremes and full-width noise mixed in.
  function automatic logic signed [VALUE_W-1:0] draw_value(int unsigned spread);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return MOST_NEG;
      2:       return MOST_POS;
      3:       return -1;
      4, 5:    return $urandom;
      default: return int'($urandom_range(0, 2 * spread)) - int'(spread);
    endcase
  endfunction

  // Extremes of the value field, repeats, zeros inside a set, and an
  // end of set falling on a repeat and on a zero.
  task automatic test_extremes();
    src_gap_max    = 3;
    sink_stall_max = 3;
    send_beat(MOST_NEG, 1'b0);
    send_beat(MOST_POS, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(1, 1'b0);
    send_beat(MOST_NEG, 1'b0);
    send_beat(0, 1'b0);
    send_beat(MOST_POS, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(0, 1'b1);
    // store must be empty again: same values take slots from zero
    send_beat(1, 1'b0);
    send_beat(MOST_NEG, 1'b0);
    send_beat(1, 1'b1);
  endtask

  // One-beat sets: zero, a fresh value, the same value again, then two more values
  task automatic test_single_beat_sets();
    send_beat(0, 1'b1);
    send_beat(MOST_NEG, 1'b1);
    send_beat(MOST_NEG, 1'b1);
    send_beat(42, 1'b1);
    send_beat(-1, 1'b1);
  endtask

  // Fill the store with random distinct values, then push past it:
  // new values overflow (again on repeat), stored ones are plain repeats.
  task automatic test_store_overflow();
    logic signed [VALUE_W-1:0] fill[$];
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] spare;
    bit                        clash;
    src_gap_max    = 2;
    sink_stall_max = 5;
    while (fill.size() < CAP + 1) begin
      v     = $urandom;
      clash = (v == 0);
      foreach (fill[i])
        if (fill[i] == v) clash = 1'b1;
      if (!clash) fill.push_back(v);
    end
    spare = fill.pop_back();
    foreach (fill[i]) send_beat(fill[i], 1'b0);
    send_beat(spare, 1'b0);
    send_beat(spare, 1'b0);
    send_beat(fill[0], 1'b0);
    send_beat(fill[CAP-1], 1'b0);
    send_beat(0, 1'b0);
    send_beat(spare, 1'b1);
    // the dropped value must now be accepted in a fresh set
    send_beat(spare, 1'b0);
    send_beat(fill[3], 1'b1);
  endtask

  // Well-formed sets of random length and content. Most sets are short;
  // about one in four is CAP-2 to CAP+16 beats long, near or past the store size.
  task automatic test_random_sets(int n_items, int unsigned gap_max,
                                  int unsigned stall_max);
    int          sent;
    int          len;
    int unsigned spread;
    src_gap_max    = gap_max;
    sink_stall_max = stall_max;
    sent           = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) len = $urandom_range(CAP - 2, CAP + 16);
      else len = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       spread = 4;
        1:       spread = 24;
        2:       spread = 64;
        default: spread = 4000;
      endcase
      for (int i = 0; i < len; i++)
        send_beat(draw_value(spread), i == len - 1);
      sent += len;
    end
  endtask

  // Sink: for each result draw a stall, then hold ready until a beat goes
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result checker: each accepted beat against the oldest expectation
  always @(posedge clk) begin
    dedup_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, value %0d", $time, out_ch.value_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("value_out", want.value, out_ch.value_out);
        check_field("kept", want.kept, out_ch.kept);
        check_field("slot", want.slot, out_ch.slot);
        check_field("distinct_count", want.count, out_ch.distinct_count);
        check_field("overflow", want.overflow, out_ch.overflow);
        check_field("set_end", want.set_end, out_ch.set_end);
      end
    end
  end

  // Watchdog: only cycles in which no beat moves on either side count
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no beat moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_results.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.set_last = 1'b0;
    src_gap_max    = 0;
    sink_stall_max = 0;
    errors         = 0;
    idle_cycles    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_single_beat_sets();
    test_store_overflow();
    // random phases: free-running, each side stalling alone, both, light
    test_random_sets(360, 0, 0);
    test_random_sets(360, 19, 0);
    test_random_sets(360, 0, 19);
    test_random_sets(360, 19, 19);
    test_random_sets(360, 4, 2);
    release_input();

    // drain, then give the row time to show any stray beat
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAP + 20) @(posedge clk);

    $display("run covered %0d sets and %0d beats: %0d kept, %0d repeats, %0d zeros,",
             n_sets, n_beats, n_kept, n_repeats, n_zeros);
    $display("  %0d dropped on a full store, %0d mismatches", n_overflow, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
